### hw/rtl/stp_pkg.sv
package stp_pkg;

  // Operation codes carried on in_op.
  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_ALLOC   = 3'd1;
  localparam logic [2:0] OP_QUERY   = 3'd2;
  localparam logic [2:0] OP_RELEASE = 3'd3;
  localparam logic [2:0] OP_RESTART = 3'd4;

  // Handles start at this value; slot 0 maps to handle 16.
  localparam logic [7:0] HANDLE_BASE = 8'h10;

  // Width of the tick counter, periods and deadlines.
  localparam int unsigned TICK_W = 16;

  // Width of the millisecond-to-microsecond product and divider steps.
  localparam int unsigned PROD_W   = 32;
  localparam int unsigned DIV_CNT_W = 6;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(PROD_W);

  // Reset value of the tick interval register.
  localparam logic [TICK_W-1:0] TICK_INTERVAL_RST = 16'd100;

  // One record of the slot memory.
  typedef struct packed {
    logic [TICK_W-1:0] period;
    logic [TICK_W-1:0] deadline;
  } slot_rec_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_READ,
    ST_EXEC,
    ST_DONE
  } stp_state_t;

  // Microseconds from milliseconds: ms * 1000 = ms*1024 - ms*16 - ms*8.
  function automatic logic [PROD_W-1:0] ms_to_us(input logic [TICK_W-1:0] ms);
    logic [PROD_W-1:0] wide;
    wide = PROD_W'(ms);
    return (wide << 10) - (wide << 4) - (wide << 3);
  endfunction

endpackage

### hw/rtl/stp_divider.sv
module stp_divider
  import stp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [PROD_W-1:0]     dividend,
  input  logic [TICK_W-1:0]     divisor,
  output logic                  busy,
  output logic [TICK_W-1:0]     quotient
);

  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [TICK_W-1:0]    rem_r, rem_nxt;
  logic [PROD_W-1:0]    quo_r, quo_nxt;
  logic [TICK_W-1:0]    dvs_r, dvs_nxt;
  logic [TICK_W:0]      trial;
  logic [TICK_W:0]      diff;
  logic                 q_bit;

  // One restoring step: shift in the next dividend bit and try to subtract.
  // A zero divisor sets every quotient bit, which saturates below.
  always_comb begin
    trial = {rem_r, quo_r[PROD_W-1]};
    diff  = trial - {1'b0, dvs_r};
    q_bit = (trial >= {1'b0, dvs_r});
  end

  // Step sequencing; the dividend shifts out as the quotient shifts in.
  always_comb begin
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    dvs_nxt = dvs_r;
    if (start) begin
      cnt_nxt = DIV_STEPS;
      rem_nxt = '0;
      quo_nxt = dividend;
      dvs_nxt = divisor;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      rem_nxt = q_bit ? diff[TICK_W-1:0] : trial[TICK_W-1:0];
      quo_nxt = {quo_r[PROD_W-2:0], q_bit};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = (cnt_r != '0);
  assign quotient = (|quo_r[PROD_W-1:TICK_W]) ? '1 : quo_r[TICK_W-1:0];

endmodule

### hw/rtl/stp_slot_mem.sv
module stp_slot_mem
  import stp_pkg::*;
#(
  parameter int NUM_SLOTS = 8,
  parameter int SLOT_W    = 3
) (
  input  logic              clk,
  input  logic              we,
  input  logic              re,
  input  logic [SLOT_W-1:0] addr,
  input  slot_rec_t         wdata,
  output slot_rec_t         rdata
);

  slot_rec_t mem [NUM_SLOTS];
  slot_rec_t rdata_r;

  // Single-port record store with a registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/soft_timer_pool.sv
// Channel | Direction | Ports                                       | Transaction
// in      | input     | in_valid, in_ready, in_op, in_time_ms,      | one command
//         |           | in_handle                                   |
// out     | output    | out_valid, out_ready, out_new_handle,       | one result
//         |           | out_success, out_timed_out                  |
// cfg     | input     | cfg_valid, cfg_ready, cfg_tick_interval_us  | interval write
//
// One command is in flight at a time; the result register lets the next
// command be accepted while a result still waits on the out channel.
// Tick, release, unknown handles and unused codes go from idle straight to the
// done state; query and restart of a live slot first pass through the read and
// exec states (registered slot memory read). For allocate, a restoring divider
// produces one quotient bit per cycle while the free-slot scan runs alongside.
// Reset is synchronous and clears the tick counter, all slots and the
// interval register to 100; a stalled result holds until out_ready.
module soft_timer_pool
  import stp_pkg::*;
#(
  parameter int NUM_SLOTS = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [2:0]   in_op,
  input  logic [15:0]  in_time_ms,
  input  logic [7:0]   in_handle,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [4:0]   out_new_handle,
  output logic         out_success,
  output logic         out_timed_out,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [15:0]  cfg_tick_interval_us
);

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

  stp_state_t state_r, state_nxt;

  logic [TICK_W-1:0]    interval_r;
  logic [TICK_W-1:0]    tick_r;
  logic [NUM_SLOTS-1:0] in_use_r;
  logic [2:0]           op_r;
  logic [SLOT_W-1:0]    slot_r;
  logic [SLOT_W-1:0]    scan_r;
  logic                 scan_done_r;
  logic                 scan_hit_r;
  logic [4:0]           res_nh_r;
  logic                 res_ok_r;
  logic                 res_to_r;
  logic                 out_valid_r;
  logic [4:0]           out_nh_r;
  logic                 out_ok_r;
  logic                 out_to_r;

  logic                 in_acc;
  logic [7:0]           h_off;
  logic                 h_valid;
  logic [SLOT_W-1:0]    h_slot;
  logic                 h_hit;
  logic                 alloc_fin;
  logic                 out_free;

  logic                 div_start;
  logic                 div_busy;
  logic [TICK_W-1:0]    div_q;

  logic                 mem_we;
  logic                 mem_re;
  logic [SLOT_W-1:0]    mem_addr;
  slot_rec_t            mem_wdata;
  slot_rec_t            mem_rdata;

  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;

  // Handle decode: only handles that name an existing slot in use are hits.
  always_comb begin
    h_off   = in_handle - HANDLE_BASE;
    h_valid = (in_handle >= HANDLE_BASE) && (h_off < 8'(NUM_SLOTS));
    h_slot  = h_off[SLOT_W-1:0];
    h_hit   = h_valid && in_use_r[h_slot];
  end

  // Allocation completes once the scan is over and, on a hit, the division too.
  assign alloc_fin = scan_done_r && (!scan_hit_r || !div_busy);

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_op == OP_ALLOC) begin
            state_nxt = ST_ALLOC;
          end else if ((in_op == OP_QUERY || in_op == OP_RESTART) && h_hit) begin
            state_nxt = ST_READ;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_ALLOC: begin
        if (alloc_fin) begin
          state_nxt = ST_DONE;
        end
      end
      ST_READ: state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer toward the divider and the slot memory.
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = slot_r;
    mem_wdata = '{period: mem_rdata.period,
                  deadline: mem_rdata.period + tick_r};
    case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        div_start = in_valid && (in_op == OP_ALLOC);
      end
      ST_ALLOC: begin
        mem_addr  = scan_r;
        mem_we    = alloc_fin && scan_hit_r;
        mem_wdata = '{period: div_q, deadline: div_q + tick_r};
      end
      ST_READ: mem_re = 1'b1;
      ST_EXEC: mem_we = (op_r == OP_RESTART);
      default: ;
    endcase
  end

  // Sequencer state and control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      interval_r  <= TICK_INTERVAL_RST;
      tick_r      <= '0;
      in_use_r    <= '0;
      out_valid_r <= 1'b0;
      scan_done_r <= 1'b0;
      scan_hit_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        interval_r <= cfg_tick_interval_us;
      end
      if (in_acc && in_op == OP_TICK) begin
        tick_r <= tick_r + 1'b1;
      end
      if (in_acc && in_op == OP_RELEASE && h_hit) begin
        in_use_r[h_slot] <= 1'b0;
      end
      // Free-slot scan, one slot per cycle from the lowest.
      if (in_acc) begin
        scan_done_r <= 1'b0;
        scan_hit_r  <= 1'b0;
      end else if (state_r == ST_ALLOC && !scan_done_r) begin
        if (!in_use_r[scan_r]) begin
          scan_done_r <= 1'b1;
          scan_hit_r  <= 1'b1;
        end else if (scan_r == LAST_SLOT) begin
          scan_done_r <= 1'b1;
        end
      end
      if (state_r == ST_ALLOC && alloc_fin && scan_hit_r) begin
        in_use_r[scan_r] <= 1'b1;
      end
      // Result register toward the out channel.
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Command and result payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r     <= in_op;
      slot_r   <= h_slot;
      scan_r   <= '0;
      res_nh_r <= '0;
      res_ok_r <= (in_op == OP_RELEASE || in_op == OP_RESTART) && h_hit;
      res_to_r <= 1'b0;
    end else if (state_r == ST_ALLOC) begin
      if (!scan_done_r && in_use_r[scan_r] && scan_r != LAST_SLOT) begin
        scan_r <= scan_r + 1'b1;
      end
      if (alloc_fin && scan_hit_r) begin
        res_nh_r <= 5'(HANDLE_BASE + 8'(scan_r));
      end
    end else if (state_r == ST_EXEC && op_r == OP_QUERY) begin
      res_to_r <= (mem_rdata.deadline < tick_r);
    end
    if (state_r == ST_DONE && out_free) begin
      out_nh_r <= res_nh_r;
      out_ok_r <= res_ok_r;
      out_to_r <= res_to_r;
    end
  end

  stp_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (ms_to_us(in_time_ms)),
    .divisor  (interval_r),
    .busy     (div_busy),
    .quotient (div_q)
  );

  stp_slot_mem #(
    .NUM_SLOTS (NUM_SLOTS),
    .SLOT_W    (SLOT_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  assign out_valid      = out_valid_r;
  assign out_new_handle = out_nh_r;
  assign out_success    = out_ok_r;
  assign out_timed_out  = out_to_r;

endmodule

### dv/tb.sv
`timescale 1ns / 100ps

module tb;
  import stp_pkg::*;

  localparam int SLOT_COUNT = 8;
  // Generous watchdog for about 1900 commands.
  localparam int CYCLE_LIMIT = 2000000;
  // Allocate runs the longest of all commands, so wait a little beyond one allocate when idle.
  localparam int SETTLE_CYCLES = 48;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int SEGMENT_ITEMS = 210;

  // Codes with no operation behind them.
  localparam logic [2:0] OP_SPARE_5 = 3'd5;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [4:0] new_handle;
    logic       success;
    logic       timed_out;
  } timer_result_t;

  typedef struct {
    logic [2:0]    op;
    logic [15:0]   ms;
    logic [7:0]    handle;
    bit            typed;
    timer_result_t want;
  } cmd_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_op;
  logic [15:0] in_time_ms;
  logic [7:0]  in_handle;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [4:0]  out_new_handle;
  logic        out_success;
  logic        out_timed_out;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_tick_interval_us;

  // Typed expectation that travels with the command on the input channel.
  bit            row_typed;
  timer_result_t row_result;

  // Mirror of the timer pool.
  logic [15:0] mdl_interval;
  logic [15:0] mdl_tick;
  logic        mdl_live     [SLOT_COUNT];
  logic [15:0] mdl_deadline [SLOT_COUNT];
  logic [15:0] mdl_period   [SLOT_COUNT];

  timer_result_t pending_results[$];
  cmd_row_t      rows[$];
  int            error_count = 0;
  int            cycle_count = 0;
  int            send_idle_pct = 22;
  int            recv_idle_pct = 80;
  int            hold_requests = 0;
  int            hold_served = 0;
  int            hold_left = 0;
  timer_result_t want_res;
  timer_result_t got_res;

  soft_timer_pool #(.NUM_SLOTS(SLOT_COUNT)) u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_op                (in_op),
    .in_time_ms           (in_time_ms),
    .in_handle            (in_handle),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_new_handle       (out_new_handle),
    .out_success          (out_success),
    .out_timed_out        (out_timed_out),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_tick_interval_us (cfg_tick_interval_us)
  );

  // 4 ns clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: watchdog expired with %0d results outstanding", $time,
               pending_results.size());
      $display("Verification failed");
      $finish;
    end
  end

  // Slot index of a live handle, or -1 when the handle names no live slot.
  function automatic int live_slot_of(input logic [7:0] h);
    int idx;
    idx = int'(h) - int'(HANDLE_BASE);
    if (idx < 0 || idx >= SLOT_COUNT) return -1;
    return mdl_live[idx] ? idx : -1;
  endfunction

  // Apply one command to the mirror and return the result it should produce.
  function automatic timer_result_t apply_command(input logic [2:0] op,
                                                  input logic [15:0] ms,
                                                  input logic [7:0] h);
    timer_result_t r;
    int            s;
    int            free_slot;
    logic [31:0]   quot;
    logic [15:0]   ticks;
    r = '0;
    s = live_slot_of(h);
    free_slot = -1;
    case (op)
      OP_TICK: begin
        mdl_tick = mdl_tick + 16'd1;
      end
      OP_ALLOC: begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (free_slot < 0 && !mdl_live[i]) free_slot = i;
        end
        if (free_slot >= 0) begin
          // Period in ticks, saturated; a zero interval saturates as well.
          if (mdl_interval == 16'd0) begin
            ticks = 16'hFFFF;
          end else begin
            quot = (32'(ms) * 32'd1000) / 32'(mdl_interval);
            ticks = (quot > 32'h0000FFFF) ? 16'hFFFF : quot[15:0];
          end
          mdl_live[free_slot] = 1'b1;
          mdl_period[free_slot] = ticks;
          mdl_deadline[free_slot] = ticks + mdl_tick;
          r.new_handle = 5'(HANDLE_BASE + 8'(free_slot));
        end
      end
      OP_QUERY: begin
        // Plain unsigned compare, deliberately not wrap-aware.
        if (s >= 0 && mdl_deadline[s] < mdl_tick) r.timed_out = 1'b1;
      end
      OP_RELEASE: begin
        if (s >= 0) begin
          mdl_live[s] = 1'b0;
          mdl_deadline[s] = 16'd0;
          mdl_period[s] = 16'd0;
          r.success = 1'b1;
        end
      end
      OP_RESTART: begin
        if (s >= 0) begin
          mdl_deadline[s] = mdl_period[s] + mdl_tick;
          r.success = 1'b1;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // Scoreboard: check each result transaction, then predict each accepted command.
  always @(posedge clk) begin
    if (!rst_n) begin
      mdl_interval = TICK_INTERVAL_RST;
      mdl_tick = 16'd0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        mdl_live[i] = 1'b0;
        mdl_deadline[i] = 16'd0;
        mdl_period[i] = 16'd0;
      end
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with nothing expected: new_handle %0d success %0d timed_out %0d",
                   $time, out_new_handle, out_success, out_timed_out);
          error_count++;
        end else begin
          want_res = pending_results.pop_front();
          if (out_new_handle !== want_res.new_handle) begin
            $display("%0t: new_handle expected %0d actual %0d", $time,
                     want_res.new_handle, out_new_handle);
            error_count++;
          end
          if (out_success !== want_res.success) begin
            $display("%0t: success expected %0d actual %0d", $time,
                     want_res.success, out_success);
            error_count++;
          end
          if (out_timed_out !== want_res.timed_out) begin
            $display("%0t: timed_out expected %0d actual %0d", $time,
                     want_res.timed_out, out_timed_out);
            error_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        got_res = apply_command(in_op, in_time_ms, in_handle);
        pending_results.push_back(row_typed ? row_result : got_res);
      end
      if (cfg_valid && cfg_ready) mdl_interval = cfg_tick_interval_us;
    end
  end

  // Result receiver: random back-pressure, plus a long hold-off on request.
  always @(negedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left = RX_HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else begin
      out_ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offer one command transaction and wait until it is accepted.
  task automatic send_cmd(input logic [2:0] op, input logic [15:0] ms, input logic [7:0] h,
                          input bit typed, input timer_result_t res);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_op = op;
    in_time_ms = ms;
    in_handle = h;
    row_typed = typed;
    row_result = res;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stop offering, wait for every outstanding result, then let the block settle.
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the tick interval while the block is idle.
  task automatic write_interval(input logic [15:0] value);
    drain_results();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_tick_interval_us = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic add_row(input logic [2:0] op, input logic [15:0] ms, input logic [7:0] h,
                         input bit typed, input logic [4:0] nh, input logic ok,
                         input logic to);
    cmd_row_t r;
    r.op = op;
    r.ms = ms;
    r.handle = h;
    r.typed = typed;
    r.want.new_handle = nh;
    r.want.success = ok;
    r.want.timed_out = to;
    rows.push_back(r);
  endtask

  // Random commands, biased toward live handles so the pool sees real traffic.
  task automatic run_segment(input int count);
    logic [2:0]  op;
    logic [15:0] ms;
    logic [7:0]  h;
    int          pick;
    int          live_slots[$];
    repeat (count) begin
      live_slots.delete();
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (mdl_live[i]) live_slots.push_back(i);
      end
      pick = $urandom_range(99);
      if (pick < 30) op = OP_TICK;
      else if (pick < 46) op = OP_ALLOC;
      else if (pick < 68) op = OP_QUERY;
      else if (pick < 84) op = OP_RELEASE;
      else if (pick < 96) op = OP_RESTART;
      else op = 3'($urandom_range(7));
      pick = $urandom_range(99);
      if (pick < 35) ms = 16'($urandom_range(7));
      else if (pick < 65) ms = 16'($urandom_range(255));
      else if (pick < 85) ms = 16'($urandom_range(65535));
      else ms = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      pick = $urandom_range(99);
      if (pick < 75 && live_slots.size() > 0)
        h = HANDLE_BASE + 8'(live_slots[$urandom_range(live_slots.size() - 1)]);
      else if (pick < 90) h = HANDLE_BASE + 8'($urandom_range(SLOT_COUNT - 1));
      else h = 8'($urandom_range(255));
      send_cmd(op, ms, h, 1'b0, '0);
    end
  endtask

  // Main sequence.
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = OP_TICK;
    in_time_ms = 16'd0;
    in_handle = 8'd0;
    cfg_valid = 1'b0;
    cfg_tick_interval_us = 16'd0;
    row_typed = 1'b0;
    row_result = '0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // Directed commands at the reset interval.
    add_row(OP_QUERY,   16'h0000, 8'd16,  1, 5'd0,  0, 0);  // free slot after reset
    add_row(OP_RELEASE, 16'h0000, 8'd16,  1, 5'd0,  0, 0);
    add_row(OP_RESTART, 16'h0000, 8'd16,  1, 5'd0,  0, 0);
    add_row(OP_SPARE_5, 16'hFFFF, 8'hFF,  1, 5'd0,  0, 0);
    add_row(OP_SPARE_7, 16'hFFFF, 8'hFF,  1, 5'd0,  0, 0);
    add_row(OP_TICK,    16'hFFFF, 8'hFF,  1, 5'd0,  0, 0);
    add_row(OP_ALLOC,   16'h0000, 8'h00,  1, 5'd16, 0, 0);  // zero period
    add_row(OP_ALLOC,   16'hFFFF, 8'hFF,  1, 5'd17, 0, 0);  // period saturates
    add_row(OP_QUERY,   16'h0000, 8'd16,  0, 5'd0,  0, 0);
    add_row(OP_TICK,    16'h0000, 8'd0,   0, 5'd0,  0, 0);
    add_row(OP_QUERY,   16'h0000, 8'd16,  0, 5'd0,  0, 0);
    add_row(OP_QUERY,   16'h0000, 8'd17,  0, 5'd0,  0, 0);  // deadline wrapped low
    add_row(OP_RESTART, 16'h0000, 8'd17,  0, 5'd0,  0, 0);
    add_row(OP_QUERY,   16'h0000, 8'd0,   1, 5'd0,  0, 0);  // null handle
    add_row(OP_QUERY,   16'h0000, 8'd255, 1, 5'd0,  0, 0);
    add_row(OP_RELEASE, 16'h0000, 8'd15,  1, 5'd0,  0, 0);
    add_row(OP_RESTART, 16'h0000, 8'd24,  1, 5'd0,  0, 0);  // just past the pool
    add_row(OP_ALLOC,   16'd1,    8'd0,   0, 5'd0,  0, 0);
    add_row(OP_ALLOC,   16'd10,   8'd0,   0, 5'd0,  0, 0);
    add_row(OP_ALLOC,   16'd100,  8'd0,   0, 5'd0,  0, 0);
    add_row(OP_ALLOC,   16'd1000, 8'd0,   0, 5'd0,  0, 0);
    add_row(OP_ALLOC,   16'd30000, 8'd0,  0, 5'd0,  0, 0);
    add_row(OP_ALLOC,   16'd5,    8'd0,   0, 5'd0,  0, 0);
    add_row(OP_ALLOC,   16'd7,    8'd0,   1, 5'd0,  0, 0);  // pool full
    add_row(OP_RELEASE, 16'h0000, 8'd23,  0, 5'd0,  0, 0);
    add_row(OP_RELEASE, 16'h0000, 8'd23,  0, 5'd0,  0, 0);  // already released
    foreach (rows[i]) send_cmd(rows[i].op, rows[i].ms, rows[i].handle, rows[i].typed,
                               rows[i].want);

    // Slow receiver.
    write_interval(16'd1);
    run_segment(SEGMENT_ITEMS);
    write_interval(16'hFFFF);
    run_segment(SEGMENT_ITEMS);
    write_interval(16'd0);
    run_segment(SEGMENT_ITEMS);

    // Slow sender.
    send_idle_pct = 80;
    recv_idle_pct = 22;
    write_interval(TICK_INTERVAL_RST);
    run_segment(SEGMENT_ITEMS);
    write_interval(16'($urandom_range(65534, 2)));
    run_segment(SEGMENT_ITEMS);
    write_interval(16'd1000);
    run_segment(SEGMENT_ITEMS);

    // Full rate, starting with a long receiver hold-off so the input stalls.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_interval(16'($urandom_range(65535)));
    hold_requests++;
    run_segment(SEGMENT_ITEMS);
    write_interval(16'hFFFF);
    run_segment(SEGMENT_ITEMS);
    write_interval(16'd1);
    run_segment(SEGMENT_ITEMS);

    drain_results();
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/stp_pkg.sv
hw/rtl/stp_divider.sv
hw/rtl/stp_slot_mem.sv
hw/rtl/soft_timer_pool.sv
dv/tb.sv
